// ===== hw/rtl/sbca_pkg.sv =====
// Shared types, constants and a helper function for the single-button code alarm.
package sbca_pkg;

  localparam int CODE_LENGTH = 3;
  localparam int TIMER_WIDTH = 16;
  localparam int NUM_DIGITS  = 2 * CODE_LENGTH;
  localparam int POS_W       = $clog2(NUM_DIGITS);
  localparam int DIGIT_W     = 4;
  localparam int DIGIT_BASE  = 10;
  localparam int CFG_W       = 16;
  localparam int OUT_POS_W   = 3;
  localparam int MODE_W      = 2;
  localparam logic [CFG_W-1:0] TIMEOUT_RESET = CFG_W'(1000);

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE  = 2'd0,
    MODE_SET   = 2'd1,
    MODE_ARMED = 2'd2
  } mode_t;

  typedef struct packed {
    logic press;
    logic motion;
    logic tick;
  } item_t;

  typedef struct packed {
    mode_t                                mode;
    logic [POS_W-1:0]                     position;
    logic [DIGIT_W-1:0]                   digit;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0]   code;
    logic [TIMER_WIDTH-1:0]               count;
    logic                                 armed;
    logic                                 press_pend;
    logic                                 motion_pend;
    logic                                 alarm;
  } state_t;

  localparam state_t STATE_RESET = '{mode: MODE_IDLE, default: '0};

  // Next decimal digit, wrapping from nine back to zero.
  function automatic logic [DIGIT_W-1:0] inc_digit(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W:0] sum;
    sum = {1'b0, d} + (DIGIT_W+1)'(1);
    if (sum >= (DIGIT_W+1)'(DIGIT_BASE)) begin
      sum = sum - (DIGIT_W+1)'(DIGIT_BASE);
    end
    return sum[DIGIT_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/sbca_if.sv =====
// Channel interfaces for items, results and the timeout configuration write.
interface sbca_item_if;
  logic valid;
  logic ready;
  logic press;
  logic motion;
  logic tick;
  modport source (output valid, press, motion, tick, input ready);
  modport sink   (input valid, press, motion, tick, output ready);
endinterface

interface sbca_result_if;
  logic       valid;
  logic       ready;
  logic       alarm_on;
  logic [1:0] mode;
  logic [2:0] digit_position;
  logic [3:0] shown_digit;
  logic       timer_running;
  modport source (output valid, alarm_on, mode, digit_position, shown_digit, timer_running,
                  input ready);
  modport sink   (input valid, alarm_on, mode, digit_position, shown_digit, timer_running,
                  output ready);
endinterface

interface sbca_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] timeout_ticks;
  modport source (output valid, timeout_ticks, input ready);
  modport sink   (input valid, timeout_ticks, output ready);
endinterface

// ===== hw/rtl/sbca_step.sv =====
// Transition logic: one item applied to the current lock state.
module sbca_step
  import sbca_pkg::*;
(
  input  state_t           cur,
  input  item_t            item,
  input  logic [CFG_W-1:0] ticks,
  output state_t           nxt
);

  logic                                 expired;
  logic                                 do_count;
  logic                                 do_commit;
  logic                                 codes_match;
  logic [DIGIT_W-1:0]                   wr_digit;
  logic [DIGIT_W-1:0]                   rd_digit;
  logic [POS_W-1:0]                     pos_inc;
  logic [NUM_DIGITS-1:0][DIGIT_W-1:0]   stored;

  always_comb begin
    codes_match = 1'b1;
    for (int k = 0; k < CODE_LENGTH; k++) begin
      if (cur.code[k] != cur.code[k + CODE_LENGTH]) begin
        codes_match = 1'b0;
      end
    end
  end

  // The digit written at the current position, then the next position's read.
  always_comb begin
    wr_digit = do_count ? inc_digit(cur.digit) : cur.digit;
    pos_inc  = cur.position + POS_W'(1);
    stored   = cur.code;
    rd_digit = '0;
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (cur.position == POS_W'(k)) begin
        stored[k] = wr_digit;
      end
    end
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (pos_inc == POS_W'(k)) begin
        rd_digit = stored[k];
      end
    end
  end

  always_comb begin
    nxt             = cur;
    nxt.press_pend  = cur.press_pend | item.press;
    nxt.motion_pend = cur.motion_pend | item.motion;
    if (item.tick && cur.armed && (cur.count != '0)) begin
      nxt.count = cur.count - TIMER_WIDTH'(1);
    end
    expired   = cur.armed && (nxt.count == '0);
    do_count  = 1'b0;
    do_commit = 1'b0;

    unique case (cur.mode)
      MODE_IDLE: begin
        if (nxt.press_pend && (cur.position == '0)) begin
          nxt.mode = MODE_SET;
          do_count = 1'b1;
        end
      end
      MODE_SET: begin
        if (nxt.press_pend && !expired) begin
          do_count = 1'b1;
        end else if (expired && (cur.position < POS_W'(CODE_LENGTH - 1))) begin
          do_commit = 1'b1;
        end else if (expired && (cur.position == POS_W'(CODE_LENGTH - 1))) begin
          nxt.motion_pend = 1'b0;
          do_commit       = 1'b1;
          nxt.mode        = MODE_ARMED;
        end
      end
      MODE_ARMED: begin
        if (nxt.press_pend && !expired) begin
          do_count = 1'b1;
        end else if (expired && (cur.position < POS_W'(NUM_DIGITS - 1))) begin
          do_commit = 1'b1;
        end else if (expired && (cur.position == POS_W'(NUM_DIGITS - 1)) && codes_match) begin
          nxt.motion_pend = 1'b0;
          nxt.armed       = 1'b0;
          nxt.alarm       = 1'b0;
          nxt.position    = '0;
          nxt.digit       = '0;
          nxt.code        = '0;
          nxt.mode        = MODE_IDLE;
        end else if (expired && (cur.position == POS_W'(NUM_DIGITS - 1))) begin
          nxt.armed    = 1'b0;
          nxt.alarm    = 1'b1;
          nxt.position = POS_W'(CODE_LENGTH);
          nxt.digit    = '0;
          for (int k = CODE_LENGTH; k < NUM_DIGITS; k++) begin
            nxt.code[k] = '0;
          end
        end else if (nxt.motion_pend) begin
          nxt.motion_pend = 1'b0;
          nxt.alarm       = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (do_count) begin
      nxt.press_pend = 1'b0;
      nxt.count      = TIMER_WIDTH'(ticks);
      nxt.armed      = 1'b1;
      nxt.digit      = wr_digit;
      nxt.code       = stored;
    end
    if (do_commit) begin
      nxt.armed    = 1'b0;
      nxt.code     = stored;
      nxt.position = pos_inc;
      nxt.digit    = rd_digit;
    end
  end

endmodule

// ===== hw/rtl/single_button_code_alarm_core.sv =====
// Top level of the single-button code lock with motion alarm.
//
// Usage: each beat on the items channel carries a button press, a motion event
// and a time tick. Every accepted item produces exactly one beat on the results
// channel with the alarm state, the mode, the digit position being entered,
// the digit currently shown and whether the digit timeout is running.
// The timeout length is written through the cfg channel, which is always ready;
// write it only while no item is in flight.
// The result is registered: the result of an item accepted at a clock edge
// is valid after that edge. Throughput is one item per cycle while results are
// taken, set by the single transition step between the state registers and the result register.
// The items channel stays ready while the result register is empty or its beat
// is being taken, so a stalled receiver holds the pending result and stops
// further items only for as long as the stall lasts.
// Reset clears the mode, position, digit, stored code, timer, alarm and pending flags,
// empties the result register and loads the timeout with 1000 ticks.
module single_button_code_alarm_core
  import sbca_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  sbca_item_if.sink            items,
  sbca_result_if.source        results,
  sbca_cfg_if.sink             cfg
);

  state_t           st;
  state_t           st_next;
  item_t            item;
  logic [CFG_W-1:0] timeout_ticks;
  logic             accept;

  assign item    = '{press: items.press, motion: items.motion, tick: items.tick};
  // The result register frees itself in the same cycle its beat is taken.
  assign items.ready = !results.valid || results.ready;
  assign accept      = items.valid && items.ready;
  assign cfg.ready   = 1'b1;

  sbca_step u_step (
    .cur   (st),
    .item  (item),
    .ticks (timeout_ticks),
    .nxt   (st_next)
  );

  // Lock state, timeout configuration and result handshake. The state only moves on an accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= STATE_RESET;
      timeout_ticks <= TIMEOUT_RESET;
      results.valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        timeout_ticks <= cfg.timeout_ticks;
      end
      if (accept) begin
        st            <= st_next;
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
    end
  end

  // Result payload is taken from the new state of the accepted item.
  always_ff @(posedge clk) begin
    if (accept) begin
      results.alarm_on       <= st_next.alarm;
      results.mode           <= st_next.mode;
      results.digit_position <= OUT_POS_W'(st_next.position);
      results.shown_digit    <= st_next.digit;
      results.timer_running  <= st_next.armed;
    end
  end

`ifndef ASSERT_OFF
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> results.valid)
    else $error("accepted item produced no result");

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (st.mode == MODE_IDLE) |-> (!st.alarm && !st.armed))
    else $error("idle mode with alarm or timer active");

  a_position_range: assert property (@(posedge clk) disable iff (rst)
    st.position <= POS_W'(NUM_DIGITS - 1))
    else $error("digit position out of range");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    st.digit < DIGIT_W'(DIGIT_BASE))
    else $error("digit is not decimal");
`endif

endmodule
